FILE: hdl/h8s_pkg.sv
// Shared types, codes and small helper functions of the brick element stiffness block.
`default_nettype none

package h8s_pkg;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POISSON  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIM  = 3'd5;

   localparam logic [14:0] POISSON_RESET = 15'd19661;

   // Final divisors: 144 on the diagonal blocks, 48 off them
   localparam logic [7:0] DIAG_DIV = 8'd144;
   localparam logic [7:0] OFF_DIV  = 8'd48;

   // Divisors split as 9 << 4 and 3 << 4; odd parts go by reciprocal multiply
   localparam int          DIV_SHIFT = 4;
   localparam logic [3:0]  DIAG_ODD  = 4'd9;
   localparam logic [3:0]  OFF_ODD   = 4'd3;
   localparam logic [63:0] RECIP_9   = 64'h1C71_C71C_71C7_1C72;  // ceil(2^64 / 9)
   localparam logic [63:0] RECIP_3   = 64'h5555_5555_5555_5556;  // ceil(2^64 / 3)

   localparam logic [4:0] INDEX_LIMIT = 5'd24;

   typedef enum logic [0:0] {
      ALU_MUL = 1'b0,
      ALU_DIV = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic         start;
      alu_op_type   op;
      logic [127:0] a;     // multiplicand, or numerator aligned to the top
      logic [63:0]  b;     // multiplier, or divisor
      logic [7:0]   len;   // divide steps
   } alu_cmd_type;

   typedef struct packed {
      logic         done;
      logic [127:0] result;
      logic [63:0]  rem;
   } alu_rsp_type;

   typedef struct packed {
      logic [31:0] modulus;
      logic [14:0] poisson;
      logic [31:0] side_l;
      logic [31:0] side_w;
      logic [31:0] side_h;
      logic [31:0] min_dim;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic signed [47:0] entry;
      logic               short_side;
      logic               sat;
   } res_type;

   typedef struct packed {
      logic [2:0] node;
      logic [1:0] dof;
   } idx_type;

   // Corner sign mask of a node: bit k set when the node sits on the + side of axis k
   function automatic logic [2:0] corner_pos(input logic [2:0] node);
      logic [2:0] mask;
      unique case (node)
         3'd0: mask = 3'b001;
         3'd1: mask = 3'b011;
         3'd2: mask = 3'b010;
         3'd3: mask = 3'b000;
         3'd4: mask = 3'b101;
         3'd5: mask = 3'b111;
         3'd6: mask = 3'b110;
         default: mask = 3'b100;
      endcase
      return mask;
   endfunction

   // Split a matrix index into node and dof by threshold compares
   function automatic idx_type split_index(input logic [4:0] idx);
      idx_type res;
      logic [2:0] node;
      node = 3'd0;
      for (int i = 1; i < 8; i++) begin
         if (idx >= 5'(3 * i)) node = 3'(i);
      end
      res.node = node;
      res.dof  = 2'(idx - 5'(node) * 5'd3);
      return res;
   endfunction

   // Next axis, cyclically
   function automatic logic [1:0] axis_next(input logic [1:0] k);
      logic [1:0] n;
      unique case (k)
         2'd0: n = 2'd1;
         2'd1: n = 2'd2;
         default: n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/h8s_if.sv
// Handshake channel interfaces: request, response and register write.
`default_nettype none

interface h8s_req_if;
   logic       valid;
   logic       ready;
   logic [4:0] row_index;
   logic [4:0] column_index;
   modport source (output valid, output row_index, output column_index, input ready);
   modport sink   (input valid, input row_index, input column_index, output ready);
endinterface

interface h8s_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] stiffness_entry;
   logic               side_too_small;
   logic               saturated;
   modport source (output valid, output stiffness_entry, output side_too_small,
                   output saturated, input ready);
   modport sink   (input valid, input stiffness_entry, input side_too_small,
                   input saturated, output ready);
endinterface

interface h8s_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/h8s_alu.sv
// Shared radix-2 arithmetic unit: shift-add multiply and restoring divide, one bit a cycle.
`default_nettype none

module h8s_alu (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire h8s_pkg::alu_cmd_type cmd_i,
   output h8s_pkg::alu_rsp_type      rsp_o
);

   localparam logic [7:0] MUL_STEPS = 8'd64;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   h8s_pkg::alu_op_type op_ff, op_in;
   logic [127:0]        a_ff, a_in;
   logic [63:0]         b_ff, b_in;
   logic [127:0]        acc_ff, acc_in;
   logic [63:0]         rem_ff, rem_in;
   logic [7:0]          cnt_ff, cnt_in;

   logic [64:0] shifted;
   logic [64:0] diff;
   logic        ge;

   // Divide step: bring down the next numerator bit and trial subtract
   assign shifted = {rem_ff, a_ff[127]};
   assign diff    = shifted - {1'b0, b_ff};
   assign ge      = shifted >= {1'b0, b_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (cmd_i.start) begin
         busy_in = 1'b1;
         op_in   = cmd_i.op;
         a_in    = cmd_i.a;
         b_in    = cmd_i.b;
         acc_in  = '0;
         rem_in  = '0;
         cnt_in  = (cmd_i.op == h8s_pkg::ALU_MUL) ? MUL_STEPS : cmd_i.len;
      end else if (busy_ff) begin
         unique case (op_ff)
            h8s_pkg::ALU_MUL: begin
               if (b_ff[0]) acc_in = acc_ff + a_ff;
               a_in = {a_ff[126:0], 1'b0};
               b_in = {1'b0, b_ff[63:1]};
            end
            default: begin
               rem_in = ge ? diff[63:0] : shifted[63:0];
               a_in   = {a_ff[126:0], ge};
            end
         endcase
         cnt_in = cnt_ff - 8'd1;
         if (cnt_ff == 8'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign rsp_o.done   = done_ff;
   assign rsp_o.result = (op_ff == h8s_pkg::ALU_MUL) ? acc_ff : a_ff;
   assign rsp_o.rem    = rem_ff;

   // A new command never lands on a running one
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_i.start |-> !busy_ff)
      else $error("alu started while busy");

endmodule

`default_nettype wire

FILE: hdl/h8s_seq.sv
// Sequencer: walks one matrix entry through the shared arithmetic unit.
`default_nettype none

module h8s_seq #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire h8s_pkg::cfg_type     cfg_i,
   input  wire logic                 start_i,
   input  wire logic [4:0]           row_i,
   input  wire logic [4:0]           col_i,
   input  wire logic                 out_free_i,
   output logic                      idle_o,
   output h8s_pkg::alu_cmd_type      alu_cmd_o,
   input  wire h8s_pkg::alu_rsp_type alu_rsp_i,
   output h8s_pkg::res_type          res_o
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   typedef enum logic [9:0] {
      STEP_EV      = 10'b00_0000_0001,  // E * v
      STEP_DL      = 10'b00_0000_0010,  // lambda denominator
      STEP_LAM     = 10'b00_0000_0100,
      STEP_G       = 10'b00_0000_1000,
      STEP_AXIS    = 10'b00_0001_0000,  // pick the next usable axis
      STEP_PROD    = 10'b00_0010_0000,  // Lm * Ln
      STEP_RATIO   = 10'b00_0100_0000,  // / Lk
      STEP_TERM    = 10'b00_1000_0000,
      STEP_OFF_LAM = 10'b01_0000_0000,
      STEP_OFF_G   = 10'b10_0000_0000
   } step_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic                final_ff, final_in;
   logic [1:0]          k_ff, k_in;
   logic [2:0]          node_a_ff, node_a_in, node_b_ff, node_b_in;
   logic [1:0]          p_ff, p_in, q_ff, q_in;
   logic [2:0]          ok_ff, ok_in;
   logic                small_ff, small_in;
   logic [63:0]         g_ff, g_in, lam_ff, lam_in, tmp_ff, tmp_in, ratio_ff, ratio_in;
   logic signed [129:0] sum_ff, sum_in;
   logic signed [47:0]  entry_ff, entry_in;
   logic                sat_ff, sat_in;

   logic [31:0]         side [3];
   h8s_pkg::idx_type    split_a, split_b;
   logic [2:0]          ok_now;
   logic [2:0]          pos_a, pos_b, eq;
   logic [1:0]          m_ax, n_ax, r_ax;
   logic [63:0]         coef, coef_w;
   logic [2:0]          diag_sh;
   logic [1:0]          off_sh;
   logic [7:0]          div_c;
   logic                diag;
   logic                sum_neg;
   logic [129:0]        sum_abs;
   logic [17:0]         vsum, vdif;
   logic                round_up;
   logic [63:0]         q_rnd;
   logic                term_pos;
   logic signed [129:0] term;
   logic [127:0]        limit, q_lim;
   logic                over;
   logic [127:0]        mag_rnd, y_q, thr;
   logic [3:0]          div_odd;
   logic [63:0]         recip;

   function automatic logic [31:0] pick_side(input logic [1:0] sel, input h8s_pkg::cfg_type c);
      logic [31:0] s;
      unique case (sel)
         2'd0: s = c.side_l;
         2'd1: s = c.side_w;
         default: s = c.side_h;
      endcase
      return s;
   endfunction

   assign side[0] = cfg_i.side_l;
   assign side[1] = cfg_i.side_w;
   assign side[2] = cfg_i.side_h;

   // Index decode and side checks at accept time
   assign split_a = h8s_pkg::split_index(row_i);
   assign split_b = h8s_pkg::split_index(col_i);
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ok_now[i] = (side[i] != 32'd0) && (side[i] >= cfg_i.min_dim);
      end
   end

   // Geometry of the node pair
   assign pos_a = h8s_pkg::corner_pos(node_a_ff);
   assign pos_b = h8s_pkg::corner_pos(node_b_ff);
   assign eq    = ~(pos_a ^ pos_b);
   assign m_ax  = h8s_pkg::axis_next(k_ff);
   assign n_ax  = h8s_pkg::axis_next(m_ax);
   assign r_ax  = 2'd3 - p_ff - q_ff;
   assign diag  = (p_ff == q_ff);

   // Weights: a factor 4 for equal corner signs, 2 otherwise
   assign coef    = (k_ff == p_ff) ? lam_ff + {g_ff[62:0], 1'b0} : g_ff;
   assign diag_sh = 3'd2 + 3'(eq[m_ax]) + 3'(eq[n_ax]);
   assign coef_w  = coef << diag_sh;
   assign off_sh  = 2'd1 + 2'(eq[r_ax]);

   assign div_c   = diag ? h8s_pkg::DIAG_DIV : h8s_pkg::OFF_DIV;
   assign sum_neg = sum_ff[129];
   assign sum_abs = sum_neg ? 130'(-sum_ff) : 130'(sum_ff);

   // Final scaling: round, drop the power of two, then the odd factor by reciprocal
   assign mag_rnd = sum_abs[127:0] + (128'(div_c >> 1) << FRAC_BITS);
   assign y_q     = mag_rnd >> (FRAC_BITS + h8s_pkg::DIV_SHIFT);
   assign div_odd = diag ? h8s_pkg::DIAG_ODD : h8s_pkg::OFF_ODD;
   assign recip   = diag ? h8s_pkg::RECIP_9 : h8s_pkg::RECIP_3;

   assign vsum = 18'd65536 + 18'(cfg_i.poisson);
   assign vdif = 18'd65536 - {2'b00, cfg_i.poisson, 1'b0};

   // Command for the current step
   always_comb begin
      alu_cmd_o.start = (state_ff == ST_ISSUE) && (final_ff || (step_ff != STEP_AXIS));
      alu_cmd_o.op    = h8s_pkg::ALU_MUL;
      alu_cmd_o.a     = '0;
      alu_cmd_o.b     = '0;
      alu_cmd_o.len   = 8'd64;
      if (final_ff) begin
         alu_cmd_o.a = {64'd0, y_q[63:0]};
         alu_cmd_o.b = recip;
      end else begin
         unique case (step_ff)
            STEP_EV: begin
               alu_cmd_o.a = 128'(cfg_i.modulus);
               alu_cmd_o.b = 64'(cfg_i.poisson);
            end
            STEP_DL: begin
               alu_cmd_o.a = 128'(vsum);
               alu_cmd_o.b = 64'(vdif);
            end
            STEP_LAM: begin
               alu_cmd_o.op = h8s_pkg::ALU_DIV;
               alu_cmd_o.a  = {tmp_ff << 16, 64'd0};
               alu_cmd_o.b  = ratio_ff;
            end
            STEP_G: begin
               alu_cmd_o.op = h8s_pkg::ALU_DIV;
               alu_cmd_o.a  = {64'(cfg_i.modulus) << 16, 64'd0};
               alu_cmd_o.b  = 64'({vsum, 1'b0});
            end
            STEP_PROD: begin
               alu_cmd_o.a = 128'(pick_side(m_ax, cfg_i));
               alu_cmd_o.b = 64'(pick_side(n_ax, cfg_i));
            end
            STEP_RATIO: begin
               alu_cmd_o.op = h8s_pkg::ALU_DIV;
               alu_cmd_o.a  = {tmp_ff, 64'd0};
               alu_cmd_o.b  = 64'(pick_side(k_ff, cfg_i));
            end
            STEP_TERM: begin
               alu_cmd_o.a = 128'(coef_w);
               alu_cmd_o.b = ratio_ff;
            end
            STEP_OFF_LAM: begin
               alu_cmd_o.a = 128'(lam_ff << off_sh);
               alu_cmd_o.b = 64'(pick_side(r_ax, cfg_i));
            end
            STEP_OFF_G: begin
               alu_cmd_o.a = 128'(g_ff << off_sh);
               alu_cmd_o.b = 64'(pick_side(r_ax, cfg_i));
            end
            default: begin
            end
         endcase
      end
   end

   // Half-up rounding of a quotient from its remainder
   assign round_up = {alu_rsp_i.rem, 1'b0} >= {1'b0, alu_cmd_o.b};
   assign q_rnd    = alu_rsp_i.result[63:0] + 64'(round_up);

   // Sign of the product just finished
   always_comb begin
      unique case (step_ff)
         STEP_OFF_LAM: term_pos = (pos_a[p_ff] == pos_b[q_ff]);
         STEP_OFF_G:   term_pos = (pos_a[q_ff] == pos_b[p_ff]);
         default:      term_pos = eq[k_ff];
      endcase
   end
   assign term = signed'({2'b00, alu_rsp_i.result});

   // Clip the final magnitude: quotient above the limit when y >= odd * (limit + 1)
   assign limit = sum_neg ? (128'd1 << 47) : ((128'd1 << 47) - 128'd1);
   assign thr   = (128'(div_odd) << 47) + (sum_neg ? 128'(div_odd) : 128'd0);
   assign over  = y_q >= thr;
   assign q_lim = over ? limit : {64'd0, alu_rsp_i.result[127:64]};

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      final_in  = final_ff;
      k_in      = k_ff;
      node_a_in = node_a_ff;
      node_b_in = node_b_ff;
      p_in      = p_ff;
      q_in      = q_ff;
      ok_in     = ok_ff;
      small_in  = small_ff;
      g_in      = g_ff;
      lam_in    = lam_ff;
      tmp_in    = tmp_ff;
      ratio_in  = ratio_ff;
      sum_in    = sum_ff;
      entry_in  = entry_ff;
      sat_in    = sat_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_i) begin
               node_a_in = split_a.node;
               node_b_in = split_b.node;
               p_in      = split_a.dof;
               q_in      = split_b.dof;
               ok_in     = ok_now;
               small_in  = ~&ok_now;
               sum_in    = '0;
               entry_in  = '0;
               sat_in    = 1'b0;
               k_in      = 2'd0;
               final_in  = 1'b0;
               step_in   = STEP_EV;
               if ((row_i >= h8s_pkg::INDEX_LIMIT) || (col_i >= h8s_pkg::INDEX_LIMIT) ||
                   ((split_a.dof != split_b.dof) &&
                    !(ok_now[split_a.dof] && ok_now[split_b.dof]))) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            if (!final_ff && (step_ff == STEP_AXIS)) begin
               if (k_ff == 2'd3) begin
                  final_in = 1'b1;
               end else if (ok_ff[k_ff]) begin
                  step_in = STEP_PROD;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (alu_rsp_i.done) begin
               state_in = ST_ISSUE;
               if (final_ff) begin
                  sat_in   = over;
                  entry_in = sum_neg ? -signed'(q_lim[47:0]) : signed'(q_lim[47:0]);
                  state_in = ST_DONE;
               end else begin
                  unique case (step_ff)
                     STEP_EV: begin
                        tmp_in  = alu_rsp_i.result[63:0];
                        step_in = STEP_DL;
                     end
                     STEP_DL: begin
                        ratio_in = alu_rsp_i.result[63:0];
                        step_in  = STEP_LAM;
                     end
                     STEP_LAM: begin
                        lam_in  = q_rnd;
                        step_in = STEP_G;
                     end
                     STEP_G: begin
                        g_in    = q_rnd;
                        step_in = diag ? STEP_AXIS : STEP_OFF_LAM;
                     end
                     STEP_PROD: begin
                        tmp_in  = alu_rsp_i.result[63:0];
                        step_in = STEP_RATIO;
                     end
                     STEP_RATIO: begin
                        ratio_in = q_rnd;
                        step_in  = STEP_TERM;
                     end
                     STEP_TERM: begin
                        sum_in  = term_pos ? sum_ff + term : sum_ff - term;
                        k_in    = k_ff + 2'd1;
                        step_in = STEP_AXIS;
                     end
                     STEP_OFF_LAM: begin
                        sum_in  = term_pos ? sum_ff + term : sum_ff - term;
                        step_in = STEP_OFF_G;
                     end
                     STEP_OFF_G: begin
                        sum_in   = term_pos ? sum_ff + term : sum_ff - term;
                        final_in = 1'b1;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         default: begin
            if (out_free_i) state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_EV;
         final_ff <= 1'b0;
         k_ff     <= 2'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         final_ff <= final_in;
         k_ff     <= k_in;
      end
      node_a_ff <= node_a_in;
      node_b_ff <= node_b_in;
      p_ff      <= p_in;
      q_ff      <= q_in;
      ok_ff     <= ok_in;
      small_ff  <= small_in;
      g_ff      <= g_in;
      lam_ff    <= lam_in;
      tmp_ff    <= tmp_in;
      ratio_ff  <= ratio_in;
      sum_ff    <= sum_in;
      entry_ff  <= entry_in;
      sat_ff    <= sat_in;
   end

   assign idle_o           = (state_ff == ST_IDLE);
   assign res_o.valid      = (state_ff == ST_DONE);
   assign res_o.entry      = entry_ff;
   assign res_o.short_side = small_ff;
   assign res_o.sat        = sat_ff;

   a_issue_only: assert property (@(posedge clock) disable iff (reset)
      alu_cmd_o.start |-> state_ff == ST_ISSUE)
      else $error("alu command outside issue state");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      alu_rsp_i.done |-> state_ff == ST_WAIT)
      else $error("alu finished while sequencer not waiting");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !out_free_i) |=> (state_ff == ST_DONE && $stable(entry_ff)))
      else $error("finished entry lost before hand-off");

endmodule

`default_nettype wire

FILE: hdl/hex8_stiffness_matrix_entry.sv
// Top level of the brick element stiffness matrix entry block.
// One request (row, column of the 24x24 matrix) yields one response. The block
// works on one request at a time through a single shared unit that does a
// shift-add multiply or a restoring divide, 64 steps of one bit per cycle. An
// entry on a diagonal dof block takes 14 operations (the last a reciprocal
// multiply for the final scaling) plus the axis selection, and the operations
// of each unusable side's axis are skipped; an off-diagonal entry takes 7
// operations; an out-of-range index or an unusable side pair is answered with
// no operation. A new request is taken as soon as the sequencer is idle, while
// the previous response may still wait in the output register. Register writes
// are taken at any time but must only be issued while the block is idle.
`default_nettype none

module hex8_stiffness_matrix_entry #(
   parameter int FRAC_BITS = 16
) (
   input wire logic     clock,
   input wire logic     reset,
   h8s_req_if.sink      req_bus,
   h8s_rsp_if.source    rsp_bus,
   h8s_csr_if.sink      csr_bus
);

   localparam logic [31:0] UNIT_Q = 32'd1 << FRAC_BITS;

   logic [31:0] modulus_ff, side_l_ff, side_w_ff, side_h_ff, min_dim_ff;
   logic [14:0] poisson_ff;

   h8s_pkg::cfg_type     cfg;
   h8s_pkg::alu_cmd_type alu_cmd;
   h8s_pkg::alu_rsp_type alu_rsp;
   h8s_pkg::res_type     res;
   logic                 seq_idle;
   logic                 out_free;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [47:0] rsp_entry_ff;
   logic               rsp_small_ff, rsp_sat_ff;

   // Configuration registers
   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= UNIT_Q;
         poisson_ff <= h8s_pkg::POISSON_RESET;
         side_l_ff  <= UNIT_Q;
         side_w_ff  <= UNIT_Q;
         side_h_ff  <= UNIT_Q;
         min_dim_ff <= 32'd1;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            h8s_pkg::CSR_MODULUS: modulus_ff <= csr_bus.data;
            h8s_pkg::CSR_POISSON: poisson_ff <= csr_bus.data[14:0];
            h8s_pkg::CSR_LENGTH:  side_l_ff  <= csr_bus.data;
            h8s_pkg::CSR_WIDTH:   side_w_ff  <= csr_bus.data;
            h8s_pkg::CSR_HEIGHT:  side_h_ff  <= csr_bus.data;
            h8s_pkg::CSR_MIN_DIM: min_dim_ff <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   assign cfg.modulus = modulus_ff;
   assign cfg.poisson = poisson_ff;
   assign cfg.side_l  = side_l_ff;
   assign cfg.side_w  = side_w_ff;
   assign cfg.side_h  = side_h_ff;
   assign cfg.min_dim = min_dim_ff;

   assign req_bus.ready = seq_idle;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   h8s_seq #(
      .FRAC_BITS (FRAC_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg_i      (cfg),
      .start_i    (req_bus.valid && seq_idle),
      .row_i      (req_bus.row_index),
      .col_i      (req_bus.column_index),
      .out_free_i (out_free),
      .idle_o     (seq_idle),
      .alu_cmd_o  (alu_cmd),
      .alu_rsp_i  (alu_rsp),
      .res_o      (res)
   );

   h8s_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd_i (alu_cmd),
      .rsp_o (alu_rsp)
   );

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res.valid && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res.valid && out_free) begin
         rsp_entry_ff <= res.entry;
         rsp_small_ff <= res.short_side;
         rsp_sat_ff   <= res.sat;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.stiffness_entry = rsp_entry_ff;
   assign rsp_bus.side_too_small  = rsp_small_ff;
   assign rsp_bus.saturated       = rsp_sat_ff;

endmodule

`default_nettype wire
